// ===== design/clkr_pkg.sv =====
package clkr_pkg;

   localparam int CAP_BITS = 10;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 10'd1000;

   // operation codes
   localparam logic [1:0] FUNC_HIT    = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_EVICT  = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ABSENT     = 3'd1;
   localparam logic [2:0] ST_NO_FREE    = 3'd2;
   localparam logic [2:0] ST_RING_EMPTY = 3'd3;
   localparam logic [2:0] ST_DUPLICATE  = 3'd4;

   typedef struct packed {
      logic valid;
      logic refb;
   } slot_flags_type;

endpackage

// ===== design/clkr_channels.sv =====
interface clkr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [63:0] key;
   modport source (output valid, func, key, input ready);
   modport sink (input valid, func, key, output ready);
endinterface

interface clkr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        evicted_valid;
   logic [63:0] evicted_key;
   modport source (output valid, status, evicted_valid, evicted_key, input ready);
   modport sink (input valid, status, evicted_valid, evicted_key, output ready);
endinterface

// ===== design/clkr_slot_store.sv =====
module clkr_slot_store
   import clkr_pkg::*;
#(
   parameter int MAX_SLOTS = 1024,
   parameter int KEY_BITS  = 64,
   parameter int SW        = 10
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [SW-1:0]       rd_addr,
   input  logic [KEY_BITS-1:0] cmp_key,
   output logic [KEY_BITS-1:0] rd_key,
   output slot_flags_type      rd_flags,
   output logic                rd_match,
   input  logic                wr_en,
   input  logic [SW-1:0]       wr_addr,
   input  logic [KEY_BITS-1:0] wr_key,
   input  slot_flags_type      wr_flags
);

   logic [KEY_BITS+1:0] mem [MAX_SLOTS];
   logic [KEY_BITS+1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_flags};
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_key   = rd_q_ff[KEY_BITS+1:2];
   assign rd_flags = rd_q_ff[1:0];
   // a resident slot holding the looked-up key
   assign rd_match = rd_flags.valid && (rd_key == cmp_key);

endmodule

// ===== design/clock_cache_replacement_core.sv =====
// clock second-chance replacement tracker
// req_bus carries one operation per transfer (func, key); rsp_bus returns one
// result per operation (status, evicted_valid, evicted_key), in order.
// hit and insert search the slot memory one slot per cycle over the slots
// handed out since the last clear; insert then claims a free slot. evict
// passes S_EPOP, S_ESLOT and S_ECHK per ring step; a step with the reference
// bit set sends the slot to the back, so up to ring_fill+1 steps.
// the slot memory read port reads one entry a cycle.
// one operation is in flight at a time; the next request is taken as soon
// as the result sits in the output register, even while rsp_bus is stalled.
// a stalled receiver holds the result; a further finished result waits.
// reset or a capacity write over apb empties the store at once: counters
// clear, never-handed-out slots read as free, no clearing pass is needed.
// the user writes capacity only while idle; the block does not enforce it.
module clock_cache_replacement_core
   import clkr_pkg::*;
#(
   parameter int MAX_SLOTS = 1024,
   parameter int KEY_BITS  = 64
) (
   input  logic              clock,
   input  logic              reset,
   clkr_req_if.sink          req_bus,
   clkr_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int SLOTS_RESET = (32'(CAP_RESET) + 1 > MAX_SLOTS) ?
                                MAX_SLOTS : 32'(CAP_RESET) + 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_POP   = 4'd2;
   localparam logic [3:0] S_INS   = 4'd3;
   localparam logic [3:0] S_EPOP  = 4'd4;
   localparam logic [3:0] S_ESLOT = 4'd5;
   localparam logic [3:0] S_ECHK  = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   // configuration
   logic [CAP_BITS-1:0] capacity_ff;
   logic [CW-1:0]       slots_ff, slots_in;
   logic                cfg_wr;
   logic [10:0]         cap_p1;

   // bookkeeping counters
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] fresh_ff, fresh_in;      // slots handed out since clear
   logic [CW-1:0] fs_cnt_ff, fs_cnt_in;    // freed slots stacked
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;

   // operation context
   logic [1:0]          func_ff, func_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [CW-1:0]       scan_idx_ff, scan_idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [SW-1:0]       rd_addr_ff, rd_addr_in;

   // pending result and output register
   logic [2:0]  res_status_ff, res_status_in;
   logic        res_ev_valid_ff, res_ev_valid_in;
   logic [63:0] res_ev_key_ff, res_ev_key_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic        rsp_ev_valid_ff;
   logic [63:0] rsp_ev_key_ff;
   logic        rsp_load;

   // slot memory port
   logic                s_rd_en, s_wr_en, s_match;
   logic [SW-1:0]       s_rd_addr, s_wr_addr;
   logic [KEY_BITS-1:0] s_rd_key, s_wr_key;
   slot_flags_type      s_rd_flags, s_wr_flags;

   // list memory: ring in the lower half, freed-slot stack in the upper half
   logic [SW-1:0] list_mem [2*MAX_SLOTS];
   logic [SW-1:0] list_q_ff;
   logic          l_rd_en, l_wr_en;
   logic [SW:0]   l_rd_addr, l_wr_addr;
   logic [SW-1:0] l_wr_data;

   logic [CW:0]   tail_sum;
   logic [SW-1:0] tail_pos;
   logic          accept, issue, found;

   clkr_slot_store #(
      .MAX_SLOTS (MAX_SLOTS),
      .KEY_BITS  (KEY_BITS),
      .SW        (SW)
   ) u_slot_store (
      .clock    (clock),
      .rd_en    (s_rd_en),
      .rd_addr  (s_rd_addr),
      .cmp_key  (key_ff),
      .rd_key   (s_rd_key),
      .rd_flags (s_rd_flags),
      .rd_match (s_match),
      .wr_en    (s_wr_en),
      .wr_addr  (s_wr_addr),
      .wr_key   (s_wr_key),
      .wr_flags (s_wr_flags)
   );

   always_ff @(posedge clock) begin
      if (l_wr_en) begin
         list_mem[l_wr_addr] <= l_wr_data;
      end
      if (l_rd_en) begin
         list_q_ff <= list_mem[l_rd_addr];
      end
   end

   // apb: capacity at byte address zero
   assign pready = 1'b1;
   assign prdata = 32'(capacity_ff);
   assign cfg_wr = psel && penable && pwrite && !paddr[2];
   assign cap_p1 = 11'(pwdata[CAP_BITS-1:0]) + 11'd1;
   assign slots_in = (32'(cap_p1) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cap_p1);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // ring tail position, head + fill modulo the ring depth
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(fill_ff);
   assign tail_pos = (tail_sum >= (CW+1)'(MAX_SLOTS)) ?
                     SW'(tail_sum - (CW+1)'(MAX_SLOTS)) : SW'(tail_sum);

   assign issue = (scan_idx_ff < fresh_ff);
   assign found = rd_pend_ff && s_match;

   always_comb begin
      state_in        = state_ff;
      fresh_in        = fresh_ff;
      fs_cnt_in       = fs_cnt_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      func_in         = func_ff;
      key_in          = key_ff;
      slot_in         = slot_ff;
      scan_idx_in     = scan_idx_ff;
      rd_pend_in      = 1'b0;
      rd_addr_in      = rd_addr_ff;
      res_status_in   = res_status_ff;
      res_ev_valid_in = res_ev_valid_ff;
      res_ev_key_in   = res_ev_key_ff;
      s_rd_en         = 1'b0;
      s_rd_addr       = scan_idx_ff[SW-1:0];
      s_wr_en         = 1'b0;
      s_wr_addr       = slot_ff;
      s_wr_key        = key_ff;
      s_wr_flags      = '{valid: 1'b1, refb: 1'b0};
      l_rd_en         = 1'b0;
      l_rd_addr       = {1'b0, head_ff};
      l_wr_en         = 1'b0;
      l_wr_addr       = {1'b0, tail_pos};
      l_wr_data       = slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in         = req_bus.func;
               key_in          = req_bus.key[KEY_BITS-1:0];
               scan_idx_in     = '0;
               res_status_in   = ST_OK;
               res_ev_valid_in = 1'b0;
               res_ev_key_in   = '0;
               case (req_bus.func)
                  FUNC_HIT, FUNC_INSERT: state_in = S_SCAN;
                  FUNC_EVICT: begin
                     if (fill_ff == '0) begin
                        res_status_in = ST_RING_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_EPOP;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // one slot read issued per cycle, compared the cycle after
            if (found) begin
               if (func_ff == FUNC_HIT) begin
                  s_wr_en       = 1'b1;
                  s_wr_addr     = rd_addr_ff;
                  s_wr_key      = s_rd_key;
                  s_wr_flags    = '{valid: 1'b1, refb: 1'b1};
                  res_status_in = ST_OK;
               end else begin
                  res_status_in = ST_DUPLICATE;
               end
               state_in = S_DONE;
            end else if (issue) begin
               s_rd_en     = 1'b1;
               rd_pend_in  = 1'b1;
               rd_addr_in  = scan_idx_ff[SW-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               // key not resident
               if (func_ff == FUNC_HIT) begin
                  res_status_in = ST_ABSENT;
                  state_in      = S_DONE;
               end else if (fs_cnt_ff != '0) begin
                  l_rd_en   = 1'b1;
                  l_rd_addr = {1'b1, SW'(fs_cnt_ff - 1'b1)};
                  fs_cnt_in = fs_cnt_ff - 1'b1;
                  state_in  = S_POP;
               end else if (fresh_ff != slots_ff) begin
                  slot_in  = SW'(fresh_ff);
                  fresh_in = fresh_ff + 1'b1;
                  state_in = S_INS;
               end else begin
                  res_status_in = ST_NO_FREE;
                  state_in      = S_DONE;
               end
            end
         end
         S_POP: begin
            slot_in  = list_q_ff;
            state_in = S_INS;
         end
         S_INS: begin
            s_wr_en  = 1'b1;
            l_wr_en  = 1'b1;
            fill_in  = fill_ff + 1'b1;
            state_in = S_DONE;
         end
         S_EPOP: begin
            l_rd_en  = 1'b1;
            head_in  = (32'(head_ff) == MAX_SLOTS - 1) ? '0 : head_ff + 1'b1;
            fill_in  = fill_ff - 1'b1;
            state_in = S_ESLOT;
         end
         S_ESLOT: begin
            slot_in   = list_q_ff;
            s_rd_en   = 1'b1;
            s_rd_addr = list_q_ff;
            state_in  = S_ECHK;
         end
         S_ECHK: begin
            s_wr_en  = 1'b1;
            s_wr_key = s_rd_key;
            l_wr_en  = 1'b1;
            if (s_rd_flags.refb) begin
               // second chance: clear the bit, back of the ring
               fill_in  = fill_ff + 1'b1;
               state_in = S_EPOP;
            end else begin
               s_wr_flags      = '{valid: 1'b0, refb: 1'b0};
               l_wr_addr       = {1'b1, fs_cnt_ff[SW-1:0]};
               fs_cnt_in       = fs_cnt_ff + 1'b1;
               res_ev_valid_in = 1'b1;
               res_ev_key_in   = 64'(s_rd_key);
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CAP_RESET;
         slots_ff     <= CW'(SLOTS_RESET);
         fresh_ff     <= '0;
         fs_cnt_ff    <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            // new capacity empties the store
            capacity_ff <= pwdata[CAP_BITS-1:0];
            slots_ff    <= slots_in;
            fresh_ff    <= '0;
            fs_cnt_ff   <= '0;
            head_ff     <= '0;
            fill_ff     <= '0;
         end else begin
            fresh_ff  <= fresh_in;
            fs_cnt_ff <= fs_cnt_in;
            head_ff   <= head_in;
            fill_ff   <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      key_ff          <= key_in;
      slot_ff         <= slot_in;
      scan_idx_ff     <= scan_idx_in;
      rd_addr_ff      <= rd_addr_in;
      res_status_ff   <= res_status_in;
      res_ev_valid_ff <= res_ev_valid_in;
      res_ev_key_ff   <= res_ev_key_in;
      if (rsp_load) begin
         rsp_status_ff   <= res_status_ff;
         rsp_ev_valid_ff <= res_ev_valid_ff;
         rsp_ev_key_ff   <= res_ev_key_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.evicted_valid = rsp_ev_valid_ff;
   assign rsp_bus.evicted_key   = rsp_ev_key_ff;

   // never more slots handed out than the store holds
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= slots_ff)
      else $error("fresh slot count beyond slot total");

   // at rest every handed-out slot is either in the ring or on the free stack
   a_conserve: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((CW+1)'(fs_cnt_ff) + (CW+1)'(fill_ff) == (CW+1)'(fresh_ff)))
      else $error("slot bookkeeping lost a slot");

   // a victim is only reported with an ok status
   a_victim_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_valid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("victim reported with error status");

endmodule

// ===== sim/clock_cache_replacement_core_tb.sv =====
`timescale 1ns / 100ps

module clock_cache_replacement_core_tb;
   import clkr_pkg::*;

   localparam int SLOT_LIMIT = 1024;
   localparam int STALL_LIMIT = 40000;   // cycles with no transfer on either channel
   localparam int SETTLE_CYCLES = 24;

   // one response as the block should present it
   typedef struct {
      logic [2:0]  status;
      logic        ev_valid;
      logic [63:0] ev_key;
   } outcome_type;

   // directed stimulus row; typed rows carry their own expected response
   typedef struct {
      logic [1:0]  func;
      logic [63:0] key;
      bit          typed;
      logic [2:0]  status;
      logic        ev_valid;
      logic [63:0] ev_key;
   } step_row_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   clkr_req_if req_bus ();
   clkr_rsp_if rsp_bus ();

   clock_cache_replacement_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // clock replacement shadow: slots, reference bits, free stack, hand ring
   // ------------------------------------------------------------------
   int unsigned      slot_total;
   logic [63:0]      slot_key [SLOT_LIMIT];
   bit               slot_live [SLOT_LIMIT];
   bit               ref_bit [SLOT_LIMIT];
   logic [9:0]       free_stk [SLOT_LIMIT];
   int unsigned      free_lvl;
   logic [9:0]       hand [SLOT_LIMIT];
   int unsigned      hand_head;
   int unsigned      hand_fill;

   outcome_type      pending_rsp [$];
   int               error_count = 0;

   // idle percentages, changed as the run moves through its stages
   int unsigned      src_idle_pct = 29;
   int unsigned      rsp_stall_pct = 87;

   // empties the store for a given capacity, as reset or a capacity write does
   function automatic void clear_store(input logic [9:0] cap);
      int unsigned n;
      n = int'(cap) + 1;
      if (n > SLOT_LIMIT) n = SLOT_LIMIT;
      slot_total = n;
      for (int i = 0; i < SLOT_LIMIT; i++) begin
         slot_key[i] = '0;
         slot_live[i] = 1'b0;
         ref_bit[i] = 1'b0;
         free_stk[i] = '0;
         hand[i] = '0;
      end
      for (int i = 0; i < n; i++) free_stk[i] = 10'(n - 1 - i);
      free_lvl = n;
      hand_head = 0;
      hand_fill = 0;
   endfunction

   function automatic int lookup_slot(input logic [63:0] k);
      for (int i = 0; i < slot_total; i++)
         if (slot_live[i] && slot_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void hand_push(input logic [9:0] s);
      hand[(hand_head + hand_fill) % SLOT_LIMIT] = s;
      hand_fill++;
   endfunction

   // applies one operation to the shadow and returns the response it causes
   function automatic outcome_type apply_op(input logic [1:0] f, input logic [63:0] k);
      outcome_type o;
      int s;
      logic [9:0] h;
      int unsigned steps;
      o.status = ST_OK;
      o.ev_valid = 1'b0;
      o.ev_key = '0;
      case (f)
         FUNC_HIT: begin
            s = lookup_slot(k);
            if (s >= 0) ref_bit[s] = 1'b1;
            else o.status = ST_ABSENT;
         end
         FUNC_INSERT: begin
            if (lookup_slot(k) >= 0) begin
               o.status = ST_DUPLICATE;
            end else if (free_lvl == 0) begin
               o.status = ST_NO_FREE;
            end else begin
               free_lvl--;
               h = free_stk[free_lvl];
               slot_key[h] = k;
               slot_live[h] = 1'b1;
               ref_bit[h] = 1'b0;
               hand_push(h);
            end
         end
         FUNC_EVICT: begin
            if (hand_fill == 0) begin
               o.status = ST_RING_EMPTY;
            end else begin
               // second chance: referenced slots go to the back with the bit cleared
               steps = 2 * hand_fill + 1;
               while (steps > 0) begin
                  steps--;
                  h = hand[hand_head];
                  hand_head = (hand_head + 1) % SLOT_LIMIT;
                  hand_fill--;
                  if (ref_bit[h]) begin
                     ref_bit[h] = 1'b0;
                     hand_push(h);
                  end else begin
                     o.ev_valid = 1'b1;
                     o.ev_key = slot_key[h];
                     slot_live[h] = 1'b0;
                     if (free_lvl < SLOT_LIMIT) begin
                        free_stk[free_lvl] = h;
                        free_lvl++;
                     end
                     break;
                  end
               end
            end
         end
         default: ;   // unused code: no change, all-zero response
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------
   // request side: one transfer per call, valid stays high into the next call
   // ------------------------------------------------------------------
   task automatic send_op(input logic [1:0] f, input logic [63:0] k,
                          input bit typed, input outcome_type typed_rsp);
      outcome_type o;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= f;
      req_bus.key <= k;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // transfer taken at this edge
      o = apply_op(f, k);
      pending_rsp.push_back(typed ? typed_rsp : o);
   endtask

   // waits until the block has answered everything, then lets it settle
   task automatic drain_block();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write of capacity: setup cycle, then access cycle (pready is always high)
   task automatic write_capacity(input logic [9:0] cap);
      req_bus.valid <= 1'b0;
      drain_block();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 3'd0;
      pwdata <= {22'd0, cap};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // register written at this edge
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      clear_store(cap);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side: random stall, in-order compare against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transfer with nothing outstanding: status %0d key %h",
                   rsp_bus.status, rsp_bus.evicted_key);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.evicted_valid !== want.ev_valid) begin
               $error("evicted_valid: expected %0d, got %0d",
                      want.ev_valid, rsp_bus.evicted_valid);
               error_count++;
            end
            if (rsp_bus.evicted_key !== want.ev_key) begin
               $error("evicted_key: expected %h, got %h", want.ev_key, rsp_bus.evicted_key);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long with no transfer anywhere means the block hung
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // directed rows, walked at reset capacity
   // ------------------------------------------------------------------
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALT5 = 64'h5555_5555_5555_5555;
   localparam logic [63:0] ALTA = 64'hAAAA_AAAA_AAAA_AAAA;

   step_row_type directed_rows [] = '{
      '{FUNC_EVICT,  64'd0, 1, ST_RING_EMPTY, 1'b0, 64'd0},   // evict on empty ring
      '{FUNC_HIT,    64'd0, 1, ST_ABSENT,     1'b0, 64'd0},   // hit on absent key
      '{2'd3,        ONES,  1, ST_OK,         1'b0, 64'd0},   // unused func code
      '{FUNC_INSERT, 64'd0, 1, ST_OK,         1'b0, 64'd0},
      '{FUNC_INSERT, ONES,  1, ST_OK,         1'b0, 64'd0},
      '{FUNC_INSERT, 64'd0, 1, ST_DUPLICATE,  1'b0, 64'd0},   // resident key again
      '{FUNC_HIT,    64'd0, 1, ST_OK,         1'b0, 64'd0},
      '{FUNC_EVICT,  64'd0, 1, ST_OK,         1'b1, ONES},    // key 0 gets a second chance
      '{FUNC_EVICT,  ONES,  1, ST_OK,         1'b1, 64'd0},
      '{FUNC_EVICT,  64'd0, 1, ST_RING_EMPTY, 1'b0, 64'd0},
      '{FUNC_INSERT, ALT5,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_INSERT, ALTA,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_HIT,    ALTA,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_HIT,    ALT5,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_HIT,    ONES,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_EVICT,  64'd0, 0, ST_OK,         1'b0, 64'd0},   // both referenced: full lap
      '{FUNC_INSERT, ONES,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_EVICT,  ALTA,  0, ST_OK,         1'b0, 64'd0},
      '{FUNC_EVICT,  64'd0, 0, ST_OK,         1'b0, 64'd0},
      '{FUNC_EVICT,  64'd0, 0, ST_OK,         1'b0, 64'd0}
   };

   // random phases: capacity and item count; small capacities keep scans short
   localparam int PHASES = 8;
   logic [9:0] phase_cap [PHASES] = '{10'd3, 10'd0, 10'd1, 10'd1023,
                                      10'd15, 10'd100, 10'd7, 10'd1000};
   int phase_items [PHASES] = '{200, 120, 120, 140, 240, 160, 220, 100};

   initial begin
      outcome_type typed_rsp;
      logic [63:0] key_pool [32];
      int pool_size;
      int sent;
      int total;
      int pick;
      logic [1:0] f;
      logic [63:0] k;

      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_HIT;
      req_bus.key <= '0;
      clear_store(CAP_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk at reset capacity
      foreach (directed_rows[i]) begin
         typed_rsp.status = directed_rows[i].status;
         typed_rsp.ev_valid = directed_rows[i].ev_valid;
         typed_rsp.ev_key = directed_rows[i].ev_key;
         send_op(directed_rows[i].func, directed_rows[i].key,
                 directed_rows[i].typed, typed_rsp);
      end

      // random phases, each after a capacity write that empties the store
      total = 0;
      foreach (phase_items[p]) total += phase_items[p];
      sent = 0;
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_cap[p]);
         // key pool about twice the slot count plus two, at most 32, so inserts, hits and misses mix
         pool_size = 2 * (int'(phase_cap[p]) + 1) + 2;
         if (pool_size > 32) pool_size = 32;
         for (int i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
         for (int n = 0; n < phase_items[p]; n++) begin
            // idle stages: receiver-heavy, then sender-heavy, then none
            if (sent < total / 3) begin
               src_idle_pct = 29;
               rsp_stall_pct = 87;
            end else if (sent < 2 * total / 3) begin
               src_idle_pct = 87;
               rsp_stall_pct = 29;
            end else begin
               src_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 35) f = FUNC_HIT;
            else if (pick < 70) f = FUNC_INSERT;
            else if (pick < 95) f = FUNC_EVICT;
            else f = 2'd3;
            if ($urandom_range(99) < 80) k = key_pool[$urandom_range(pool_size - 1)];
            else k = {$urandom, $urandom};
            send_op(f, k, 1'b0, typed_rsp);
            sent++;
         end
      end

      req_bus.valid <= 1'b0;
      drain_block();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== clock_cache_replacement_core.f =====
design/clkr_pkg.sv
design/clkr_channels.sv
design/clkr_slot_store.sv
design/clock_cache_replacement_core.sv
sim/clock_cache_replacement_core_tb.sv
